>>> rtl/core/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg: shared types and constants for the LRU key cache
// Entry, query and result layouts, widths and the control state encoding.
// ----------------------------------------------------------------------------
package lkc_pkg;

  localparam int unsigned CACHE_DEPTH = 16;
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned REC_W       = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned IDX_W       = $clog2(CACHE_DEPTH);
  localparam int unsigned OCC_W       = $clog2(CACHE_DEPTH + 1);
  localparam int unsigned CAP_W       = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(CACHE_DEPTH);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] rec;
  } entry_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_id;
    logic             in_backing;
    logic [REC_W-1:0] fill_record;
  } query_t;

  typedef struct packed {
    logic             hit;
    logic             found;
    logic [REC_W-1:0] record_out;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [CNT_W-1:0] hits_total;
    logic [CNT_W-1:0] misses_total;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD,
    ST_RESP
  } state_e;

endpackage

>>> rtl/core/lru_key_cache.sv
// ----------------------------------------------------------------------------
// lru_key_cache: fully associative LRU cache with move-to-front update
// Top level: query sequencer, counters, capacity register and cell chain.
// ----------------------------------------------------------------------------
// A query runs through the sequencer states in order: the beat is taken in
// idle; in lookup every cell compares its key in parallel and the hit, the
// oldest entry and the hit record are picked; update shifts the cell chain
// and updates the counters; valid_o presents the result in the result
// state. The shift needs no extra state because every entry moves by at
// most one position per query. busy is high after the accepted beat until
// the result cycle ends, so a new query may start in the cycle after
// valid_o. The result is shown for exactly that one cycle and cannot be
// held off, so the receiver must capture it then. Capacity must be written
// with cfg_we_i only while the block is idle; the block does not enforce
// this. A value of zero acts as one and values above sixteen act as sixteen.
module lru_key_cache (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  lkc_pkg::query_t            req_i,
  output logic                       valid_o,
  output lkc_pkg::result_t           rsp_o,
  input  logic                       cfg_we_i,
  input  logic [lkc_pkg::CAP_W-1:0]  cfg_wdata_i
);
  import lkc_pkg::*;

  state_e state_q, state_d;

  query_t           query_q;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] hits_q, hits_d;
  logic [CNT_W-1:0] miss_q, miss_d;
  logic [CAP_W-1:0] cap_q;
  result_t          rsp_q, rsp_d;

  logic             hit_q;
  logic [IDX_W-1:0] pos_q;
  logic [REC_W-1:0] hit_rec_q;
  logic [KEY_W-1:0] last_key_q;

  logic             accept;
  logic             look_en;
  logic             upd_en;

  entry_t               cell_q   [CACHE_DEPTH];
  entry_t               cell_in  [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] cell_en;
  logic [CACHE_DEPTH-1:0] match;

  logic             any_hit;
  logic [IDX_W-1:0] hit_pos;
  logic [REC_W-1:0] hit_rec;
  logic [KEY_W-1:0] last_key;
  logic [IDX_W-1:0] last_idx;

  logic [OCC_W-1:0] eff_cap;
  logic             full;
  logic             insert;
  logic [OCC_W-1:0] keep_occ;
  logic [OCC_W-1:0] shift_lim;
  entry_t           head;

  assign accept = start && !busy;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_LOOK;
      end
      ST_LOOK: state_d = ST_UPD;
      ST_UPD:  state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Per-state controls
  always_comb begin
    busy    = 1'b1;
    look_en = 1'b0;
    upd_en  = 1'b0;
    valid_o = 1'b0;
    case (state_q)
      ST_IDLE: busy = 1'b0;
      ST_LOOK: look_en = 1'b1;
      ST_UPD:  upd_en = 1'b1;
      ST_RESP: valid_o = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q   <= '0;
      hits_q  <= '0;
      miss_q  <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      hits_q  <= hits_d;
      miss_q  <= miss_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Capture the query beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      query_q <= req_i;
    end
  end

  // Cell chain: cell 0 takes the head, others take their younger neighbour
  for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
    logic m_raw;
    if (i == 0) begin : g_head
      assign cell_in[i] = head;
    end else begin : g_link
      assign cell_in[i] = cell_q[i-1];
    end
    assign cell_en[i] = upd_en && (hit_q || insert) && (OCC_W'(i) <= shift_lim);
    lkc_cell u_cell (
      .clk_i     (clk_i),
      .en_i      (cell_en[i]),
      .entry_i   (cell_in[i]),
      .cmp_key_i (query_q.key_id),
      .entry_o   (cell_q[i]),
      .match_o   (m_raw)
    );
    // Only occupied positions take part in the lookup
    assign match[i] = m_raw && (OCC_W'(i) < occ_q);
  end

  // Pick the youngest match, its record and the oldest occupied key
  assign last_idx = IDX_W'(occ_q - OCC_W'(1));

  always_comb begin
    any_hit  = 1'b0;
    hit_pos  = '0;
    hit_rec  = '0;
    last_key = '0;
    for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        any_hit = 1'b1;
        hit_pos = IDX_W'(i);
        hit_rec = cell_q[i].rec;
      end
      if (last_idx == IDX_W'(i)) begin
        last_key = cell_q[i].key;
      end
    end
  end

  // Hold the lookup outcome for the update cycle
  always_ff @(posedge clk_i) begin
    if (look_en) begin
      hit_q      <= any_hit;
      pos_q      <= hit_pos;
      hit_rec_q  <= hit_rec;
      last_key_q <= last_key;
    end
  end

  // Update plan: promote on a hit, insert at the front on a backed miss
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = OCC_W'(1);
    end else if (cap_q > CAP_W'(CACHE_DEPTH)) begin
      eff_cap = OCC_W'(CACHE_DEPTH);
    end else begin
      eff_cap = OCC_W'(cap_q);
    end
    full     = (occ_q >= eff_cap);
    insert   = !hit_q && query_q.in_backing;
    keep_occ = full ? (eff_cap - OCC_W'(1)) : occ_q;
    shift_lim = hit_q ? OCC_W'(pos_q) : keep_occ;
    head.key = query_q.key_id;
    head.rec = hit_q ? hit_rec_q : query_q.fill_record;
  end

  // Advance occupancy, counters and the result
  always_comb begin
    occ_d  = occ_q;
    hits_d = hits_q;
    miss_d = miss_q;
    rsp_d  = rsp_q;
    if (upd_en) begin
      if (hit_q) begin
        hits_d = hits_q + CNT_W'(1);
      end else begin
        miss_d = miss_q + CNT_W'(1);
      end
      if (insert) begin
        occ_d = keep_occ + OCC_W'(1);
      end
      rsp_d.hit          = hit_q;
      rsp_d.found        = hit_q || query_q.in_backing;
      rsp_d.record_out   = hit_q ? hit_rec_q :
                           (query_q.in_backing ? query_q.fill_record : '0);
      rsp_d.evicted      = insert && full;
      rsp_d.evicted_key  = (insert && full) ? last_key_q : '0;
      rsp_d.hits_total   = hits_d;
      rsp_d.misses_total = miss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule

>>> rtl/core/lkc_cell.sv
// ----------------------------------------------------------------------------
// lkc_cell: one position of the recency-ordered entry chain
// Holds a key and record, compares the key against the query and loads
// the entry offered by its younger neighbour when enabled.
// ----------------------------------------------------------------------------
module lkc_cell (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  lkc_pkg::entry_t            entry_i,
  input  logic [lkc_pkg::KEY_W-1:0]  cmp_key_i,
  output lkc_pkg::entry_t            entry_o,
  output logic                       match_o
);
  import lkc_pkg::*;

  entry_t entry_q;

  // Load from the neighbour; payload only, no reset
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= entry_i;
    end
  end

  // Compare the stored key with the query
  assign match_o = (entry_q.key == cmp_key_i);
  assign entry_o = entry_q;

endmodule
